### hdl/sdes_pkg.sv
// Types, tables and permutation functions shared by the S-DES block cipher.
`timescale 1ns / 1ps
`default_nettype none

package sdes_pkg;

  localparam int unsigned KeyWidth   = 10;
  localparam int unsigned BlockWidth = 8;
  localparam int unsigned SubkeyWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CFG_CIPHER_KEY   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DECRYPT_MODE = 2'd1;

  localparam logic [KeyWidth-1:0] CIPHER_KEY_RESET = 10'd642;

  // S-boxes, indexed by {row, column}.
  localparam logic [1:0] SBOX0 [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam logic [1:0] SBOX1 [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  typedef struct packed {
    logic [SubkeyWidth-1:0] first;
    logic [SubkeyWidth-1:0] second;
  } subkeys_t;

  // In every table, position one is the most significant bit.
  function automatic logic [9:0] p10(input logic [9:0] k);
    p10 = {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
  endfunction

  function automatic logic [7:0] p8(input logic [9:0] k);
    p8 = {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
  endfunction

  function automatic logic [9:0] rotl_halves(input logic [9:0] k);
    rotl_halves = {k[8:5], k[9], k[3:0], k[4]};
  endfunction

  function automatic logic [7:0] ip(input logic [7:0] b);
    ip = {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
  endfunction

  function automatic logic [7:0] ip_inv(input logic [7:0] b);
    ip_inv = {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
  endfunction

  function automatic logic [7:0] expand(input logic [3:0] r);
    expand = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
  endfunction

  function automatic logic [3:0] p4(input logic [3:0] s);
    p4 = {s[2], s[0], s[1], s[3]};
  endfunction

  // Round function F: expansion, key mixing, S-boxes and P4.
  function automatic logic [3:0] round_f(input logic [3:0] r, input logic [7:0] sk);
    logic [7:0] x;
    logic [1:0] s0;
    logic [1:0] s1;
    x  = expand(r) ^ sk;
    s0 = SBOX0[{x[7], x[4], x[6:5]}];
    s1 = SBOX1[{x[3], x[0], x[2:1]}];
    round_f = p4({s0, s1});
  endfunction

  // Two Feistel rounds with a swap between them, wrapped in IP and its inverse.
  function automatic logic [7:0] cipher(input logic [7:0] blk, input subkeys_t sk);
    logic [7:0] b;
    logic [3:0] l;
    logic [3:0] r;
    b = ip(blk);
    l = b[7:4] ^ round_f(b[3:0], sk.first);
    r = b[3:0] ^ round_f(l, sk.second);
    cipher = ip_inv({r, l});
  endfunction

endpackage

`default_nettype wire

### hdl/sdes_key_sched.sv
// Configuration registers and key schedule of the S-DES block cipher.
`timescale 1ns / 1ps
`default_nettype none

module sdes_key_sched (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sdes_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [sdes_pkg::KeyWidth-1:0]      cfg_data_i,
  output sdes_pkg::subkeys_t                      subkeys_o
);

  logic [sdes_pkg::KeyWidth-1:0] key_q, key_d;
  logic                          decrypt_q, decrypt_d;
  logic [sdes_pkg::KeyWidth-1:0] rot1;
  logic [sdes_pkg::KeyWidth-1:0] rot3;
  logic [sdes_pkg::SubkeyWidth-1:0] k1;
  logic [sdes_pkg::SubkeyWidth-1:0] k2;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_d     = key_q;
    decrypt_d = decrypt_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdes_pkg::CFG_CIPHER_KEY:   key_d     = cfg_data_i;
        sdes_pkg::CFG_DECRYPT_MODE: decrypt_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= sdes_pkg::CIPHER_KEY_RESET;
      decrypt_q <= 1'b0;
    end else begin
      key_q     <= key_d;
      decrypt_q <= decrypt_d;
    end
  end

  // Subkey one takes one rotation of each half, subkey two three in total.
  assign rot1 = sdes_pkg::rotl_halves(sdes_pkg::p10(key_q));
  assign rot3 = sdes_pkg::rotl_halves(sdes_pkg::rotl_halves(rot1));
  assign k1   = sdes_pkg::p8(rot1);
  assign k2   = sdes_pkg::p8(rot3);

  assign subkeys_o.first  = decrypt_q ? k2 : k1;
  assign subkeys_o.second = decrypt_q ? k1 : k2;

endmodule

`default_nettype wire

### hdl/simplified_des_block_cipher.sv
// Top level of the S-DES block cipher: input register, cipher logic, result register.
// Usage:
// An 8-bit block arrives on block_in_i with a valid/ready handshake and the
// cipher result leaves on block_out_o with its own valid/ready handshake.
// The key (register 0, ten bits) and the direction (register 1, set for
// decryption) are written through the cfg channel, which is always ready;
// write them only while no word is in flight.
// An accepted word is held in the input register, passes both rounds on its
// way into the result register and is shown from there. Throughput is one
// word per cycle while the receiver takes results, set by the single pass
// through both rounds between the two registers.
// When the receiver stalls, the result register holds its word and the
// input register can still take one more; the input side drops ready only
// when both are full and the output is not being taken.
// Reset empties both registers and loads key 642 in encrypt mode.
`timescale 1ns / 1ps
`default_nettype none

module simplified_des_block_cipher (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               block_in_valid_i,
  output logic                                    block_in_ready_o,
  input  wire logic [sdes_pkg::BlockWidth-1:0]    block_in_i,
  output logic                                    block_out_valid_o,
  input  wire logic                               block_out_ready_i,
  output logic [sdes_pkg::BlockWidth-1:0]         block_out_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sdes_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [sdes_pkg::KeyWidth-1:0]      cfg_data_i
);

  sdes_pkg::subkeys_t subkeys;

  logic                              s1_valid_q, s1_valid_d;
  logic [sdes_pkg::BlockWidth-1:0]   s1_data_q;
  logic                              out_valid_q, out_valid_d;
  logic [sdes_pkg::BlockWidth-1:0]   out_data_q;
  logic                              out_load;
  logic                              in_take;

  sdes_key_sched u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .subkeys_o   (subkeys)
  );

  // The result register may load when it is empty or its word leaves now.
  assign out_load         = !out_valid_q || block_out_ready_i;
  assign block_in_ready_o = !s1_valid_q || out_load;
  assign in_take          = block_in_valid_i && block_in_ready_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
    end
    if (block_in_ready_o) begin
      s1_valid_d = block_in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= block_in_i;
    end
    if (out_load && s1_valid_q) begin
      out_data_q <= sdes_pkg::cipher(s1_data_q, subkeys);
    end
  end

  assign block_out_valid_o = out_valid_q;
  assign block_out_o       = out_data_q;

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_load |=> out_valid_q)
    else $error("word in the input register was not moved to the result register");

  a_full_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !block_in_ready_o |-> s1_valid_q && out_valid_q && !block_out_ready_i)
    else $error("input side not ready although the pipeline can advance");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_load |=> s1_valid_q && $stable(s1_data_q))
    else $error("held word in the input register was lost or changed");

endmodule

`default_nettype wire

### sim/tb_simplified_des_block_cipher.sv
// Self-checking testbench for the S-DES block cipher, with its own cipher predictor.
`timescale 1ns / 1ps

module tb_simplified_des_block_cipher;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned MaxShown     = 30;
  localparam int unsigned SettleCycles = 4;

  // Indexes past the register list. A write to either of them must change nothing.
  localparam logic [sdes_pkg::CfgIdxWidth-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [sdes_pkg::CfgIdxWidth-1:0] CFG_SPARE_HI = 2'd3;

  typedef logic [sdes_pkg::BlockWidth-1:0] block_t;
  typedef logic [sdes_pkg::KeyWidth-1:0]   key_t;

  // Permutation tables packed four bits per entry, first entry highest.
  // Entry values count source bits from one, starting at the most significant bit.
  localparam logic [39:0] TabP10   = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9,
                                      4'd8, 4'd6};
  localparam logic [39:0] TabP8    = {8'd0, 4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
  localparam logic [39:0] TabIp    = {8'd0, 4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
  localparam logic [39:0] TabIpInv = {8'd0, 4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
  localparam logic [39:0] TabEp    = {8'd0, 4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
  localparam logic [39:0] TabP4    = {24'd0, 4'd2, 4'd4, 4'd3, 4'd1};

  // S-boxes, row by row, first entry highest.
  localparam logic [31:0] SboxLeft  = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                       2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [31:0] SboxRight = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                       2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  logic   clk       = 1'b0;
  logic   rst_ni    = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  block_t in_block  = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  block_t out_block;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic [sdes_pkg::CfgIdxWidth-1:0] cfg_index = sdes_pkg::CFG_CIPHER_KEY;
  key_t   cfg_data  = '0;

  // Register contents as the predictor sees them.
  key_t key_now     = sdes_pkg::CIPHER_KEY_RESET;
  logic decrypt_now = 1'b0;

  block_t cipher_expected_q [$];
  int     error_count     = 0;
  int     blocks_checked  = 0;
  int     reg_writes      = 0;
  int     cycle_count     = 0;
  int     hold_off_cycles = 0;
  bit     gaps_on         = 1'b1;

  simplified_des_block_cipher dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .block_in_valid_i (in_valid),
    .block_in_ready_o (in_ready),
    .block_in_i       (in_block),
    .block_out_valid_o(out_valid),
    .block_out_ready_i(out_ready),
    .block_out_o      (out_block),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Run stopped at the cycle limit with %0d words outstanding.",
             cipher_expected_q.size());
    $display("tb_simplified_des_block_cipher NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [9:0] select_bits(input logic [9:0] src, input int width,
                                             input logic [39:0] order, input int count);
    logic [9:0] acc;
    int         pos;
    acc = '0;
    for (int i = 0; i < count; i++) begin
      pos = int'(order[4*(count-1-i) +: 4]);
      acc = {acc[8:0], src[width - pos]};
    end
    return acc;
  endfunction

  function automatic logic [9:0] rotate_key_halves(input logic [9:0] k);
    logic [4:0] hi;
    logic [4:0] lo;
    hi = k[9:5];
    lo = k[4:0];
    return {hi[3:0], hi[4], lo[3:0], lo[4]};
  endfunction

  function automatic logic [3:0] feistel_mix(input logic [3:0] half, input logic [7:0] subkey);
    logic [9:0] wide;
    logic [7:0] x;
    logic [3:0] row_col_l;
    logic [3:0] row_col_r;
    logic [3:0] sboxed;
    wide = select_bits({6'd0, half}, 4, TabEp, 8);
    x = wide[7:0] ^ subkey;
    // The row comes from the outer bits of each nibble, the column from the inner two.
    row_col_l = {x[7], x[4], x[6:5]};
    row_col_r = {x[3], x[0], x[2:1]};
    sboxed = {SboxLeft[2*(15-int'(row_col_l)) +: 2], SboxRight[2*(15-int'(row_col_r)) +: 2]};
    wide = select_bits({6'd0, sboxed}, 4, TabP4, 4);
    return wide[3:0];
  endfunction

  function automatic block_t sdes_predict(input block_t blk);
    logic [9:0] k;
    logic [9:0] wide;
    logic [7:0] sub1;
    logic [7:0] sub2;
    logic [7:0] first;
    logic [7:0] second;
    logic [3:0] left;
    logic [3:0] right;
    logic [3:0] swap_tmp;
    k = rotate_key_halves(select_bits(key_now, 10, TabP10, 10));
    wide = select_bits(k, 10, TabP8, 8);
    sub1 = wide[7:0];
    k = rotate_key_halves(rotate_key_halves(k));
    wide = select_bits(k, 10, TabP8, 8);
    sub2 = wide[7:0];
    first  = decrypt_now ? sub2 : sub1;
    second = decrypt_now ? sub1 : sub2;
    wide = select_bits({2'b00, blk}, 8, TabIp, 8);
    left  = wide[7:4] ^ feistel_mix(wide[3:0], first);
    right = wide[3:0];
    swap_tmp = left;
    left  = right;
    right = swap_tmp;
    left = left ^ feistel_mix(right, second);
    wide = select_bits({2'b00, left, right}, 8, TabIpInv, 8);
    return wide[7:0];
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    if (error_count < MaxShown) $display("[%0t] MISMATCH %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    block_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (cipher_expected_q.size() == 0) begin
        report_mismatch($sformatf("result word %02h with none expected", out_block));
      end else begin
        want = cipher_expected_q.pop_front();
        if (out_block !== want)
          report_mismatch($sformatf("block_out %02h, expected %02h (key %03h, decrypt %0b)",
                                    out_block, want, key_now, decrypt_now));
        blocks_checked++;
      end
    end
  end

  // Receiver: random short stalls, plus a long hold-off when one is requested.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_block(input block_t blk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_block <= blk;
    do @(posedge clk); while (!in_ready);
    cipher_expected_q = {cipher_expected_q, sdes_predict(blk)};
  endtask

  task automatic send_random_blocks(input int count);
    for (int i = 0; i < count; i++) send_block(block_t'($urandom_range(0, 255)));
  endtask

  // Waits for every expected word, then lets the pipeline settle.
  task automatic drain_cipher;
    in_valid <= 1'b0;
    while (cipher_expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [sdes_pkg::CfgIdxWidth-1:0] idx, input key_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sdes_pkg::CFG_CIPHER_KEY:   key_now = data;
      sdes_pkg::CFG_DECRYPT_MODE: decrypt_now = data[0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_settings;
    // With the reset key, the classic example maps 97 to 38.
    send_block(8'h00);
    send_block(8'hFF);
    send_block(8'h97);
    send_block(8'h01);
    send_block(8'h80);
    send_block(8'h5A);
    drain_cipher();
  endtask

  task automatic test_key_extremes;
    write_register(sdes_pkg::CFG_CIPHER_KEY, 10'h000);
    send_block(8'h00);
    send_block(8'hFF);
    drain_cipher();
    write_register(sdes_pkg::CFG_CIPHER_KEY, 10'h3FF);
    send_block(8'h00);
    send_block(8'hFF);
    send_block(8'h3C);
    drain_cipher();
    // Only the lowest data bit selects the direction.
    write_register(sdes_pkg::CFG_DECRYPT_MODE, 10'h3FF);
    send_block(8'h00);
    send_block(8'hFF);
    send_block(8'h97);
    drain_cipher();
    write_register(sdes_pkg::CFG_CIPHER_KEY, sdes_pkg::CIPHER_KEY_RESET);
    send_block(8'h38);
    drain_cipher();
    write_register(CFG_SPARE_LO, 10'h000);
    write_register(CFG_SPARE_HI, 10'h3FF);
    send_block(8'h97);
    send_block(8'h6C);
    drain_cipher();
    write_register(sdes_pkg::CFG_DECRYPT_MODE, 10'h3FE);
    send_block(8'h97);
    drain_cipher();
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    key_t key_pick;
    for (int p = 0; p < phases; p++) begin
      if (p == 0)      key_pick = 10'h000;
      else if (p == 1) key_pick = 10'h3FF;
      else             key_pick = key_t'($urandom_range(0, 1023));
      if ($urandom_range(0, 1) == 0) begin
        write_register(sdes_pkg::CFG_CIPHER_KEY, key_pick);
        write_register(sdes_pkg::CFG_DECRYPT_MODE, key_t'($urandom_range(0, 1023)));
      end else begin
        write_register(sdes_pkg::CFG_DECRYPT_MODE, key_t'($urandom_range(0, 1023)));
        write_register(sdes_pkg::CFG_CIPHER_KEY, key_pick);
      end
      if ($urandom_range(0, 2) == 0)
        write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                       key_t'($urandom_range(0, 1023)));
      send_random_blocks(per_phase);
      drain_cipher();
    end
  endtask

  // The receiver holds off while words keep coming, so the block fills and stalls its input.
  task automatic test_backpressure;
    hold_off_cycles = 60;
    send_random_blocks(30);
    drain_cipher();
  endtask

  task automatic test_full_rate;
    gaps_on = 1'b0;
    write_register(sdes_pkg::CFG_CIPHER_KEY, key_t'($urandom_range(0, 1023)));
    write_register(sdes_pkg::CFG_DECRYPT_MODE, key_t'($urandom_range(0, 1)));
    send_random_blocks(400);
    drain_cipher();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    test_reset_settings();
    test_key_extremes();
    test_random_settings(9, 150);
    test_backpressure();
    test_full_rate();
    $display("Checked %0d cipher words across %0d register writes in both directions,",
             blocks_checked, reg_writes);
    $display("with random stalls on both sides, a long output hold-off and a full-rate burst.");
    if (error_count == 0) begin
      $display("tb_simplified_des_block_cipher OK");
    end else begin
      $display("%0d mismatches in total.", error_count);
      $display("tb_simplified_des_block_cipher NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hdl/sdes_pkg.sv
hdl/sdes_key_sched.sv
hdl/simplified_des_block_cipher.sv
sim/tb_simplified_des_block_cipher.sv
